// ===== rtl/core/ccec_pkg.sv =====
// shared types, constants and helpers for the cyclic code encoder and checker
package ccec_pkg;

  localparam int unsigned CODE_BITS = 64;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned POS_W     = $clog2(DATA_W);
  localparam int unsigned STEPS_PER_STAGE = 8;
  localparam int unsigned DIV_STAGES      = DATA_W / STEPS_PER_STAGE;

  localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(DATA_W - 1);
  localparam logic [DATA_W-1:0] CODE_MASK = {DATA_W{1'b1}} >> (DATA_W - CODE_BITS);
  localparam logic [DATA_W-1:0] GEN_RESET = DATA_W'(11);

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  // one request as it moves through the division stages
  typedef struct packed {
    logic              act;
    logic              bad;
    logic [POS_W-1:0]  lim;   // last step index that may subtract
    logic [DATA_W-1:0] x;     // running remainder
    logic [DATA_W-1:0] orig;  // shifted message, kept for the codeword
    logic [DATA_W-1:0] gn;    // generator with its top bit at the msb
  } ccec_item_t;

  // position of the highest set bit, zero for an all-zero word
  function automatic logic [POS_W-1:0] top_bit(logic [DATA_W-1:0] v);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int unsigned i = 0; i < DATA_W; i++) begin
      if (v[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/cyclic_code_encode_and_check.sv =====
// pipeline: two front stages, eight division stages of eight bit steps each,
// and one output register
// throughput: one request per cycle; the whole pipeline advances together
// and holds while the output register waits to be taken
// reset: all valid bits clear, generator returns to x^3 + x + 1
module cyclic_code_encode_and_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ccec_pkg::DATA_W-1:0]  cfg_generator_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [ccec_pkg::DATA_W-1:0]  value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccec_pkg::DATA_W-1:0]  word_o,
  output logic                         syndrome_zero_o,
  output logic                         bad_generator_o
);
  import ccec_pkg::*;

  logic [DATA_W-1:0] gen_q;
  logic              pipe_en;
  logic              front_valid;
  ccec_item_t        front_item;
  logic              div_valid;
  ccec_item_t        div_item;

  logic              out_valid_q;
  logic [DATA_W-1:0] word_q;
  logic [DATA_W-1:0] word_d;
  logic              szero_q;
  logic              szero_d;
  logic              bad_q;

  assign pipe_en     = !out_valid_q || out_ready_i;
  assign in_ready_o  = pipe_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= GEN_RESET;
    end else if (cfg_valid_i) begin
      gen_q <= cfg_generator_i;
    end
  end

  ccec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .value_i     (value_i),
    .generator_i (gen_q),
    .valid_o     (front_valid),
    .item_o      (front_item)
  );

  ccec_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (front_valid),
    .item_i  (front_item),
    .valid_o (div_valid),
    .item_o  (div_item)
  );

  // final remainder is the syndrome; encode merges it under the shifted message; a bad generator gives a zero word
  always_comb begin
    if (div_item.bad) begin
      word_d = '0;
    end else if (div_item.act == ACT_CHECK) begin
      word_d = div_item.x & CODE_MASK;
    end else begin
      word_d = (div_item.orig | div_item.x) & CODE_MASK;
    end
    szero_d = (div_item.act == ACT_CHECK) && !div_item.bad && (div_item.x == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      word_q  <= word_d;
      szero_q <= szero_d;
      bad_q   <= div_item.bad;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign word_o          = word_q;
  assign syndrome_zero_o = szero_q;
  assign bad_generator_o = bad_q;

  a_bad_clears_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_generator_o |-> (word_o == '0) && !syndrome_zero_o)
    else $error("bad generator result carries nonzero fields");

  a_zero_flag_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && syndrome_zero_o |-> (word_o == '0))
    else $error("syndrome flagged zero with nonzero word");

  a_word_in_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((word_o & ~CODE_MASK) == '0))
    else $error("result word has bits above the code width");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(div_valid) && $stable(div_item))
    else $error("division pipeline moved during a stall");

endmodule

// ===== rtl/core/ccec_front.sv =====
// input capture, degree search and operand alignment ahead of the division stages
module ccec_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic                         action_i,
  input  logic [ccec_pkg::DATA_W-1:0]  value_i,
  input  logic [ccec_pkg::DATA_W-1:0]  generator_i,
  output logic                         valid_o,
  output ccec_pkg::ccec_item_t         item_o
);
  import ccec_pkg::*;

  logic              s0_valid_q;
  logic              s0_act_q;
  logic              s0_bad_q;
  logic [POS_W-1:0]  s0_r_q;
  logic [DATA_W-1:0] s0_v_q;
  logic [DATA_W-1:0] s0_g_q;

  logic              s1_valid_q;
  ccec_item_t        s1_item_q;
  ccec_item_t        s1_item_d;

  logic [DATA_W-1:0] g_masked;
  logic [DATA_W-1:0] shifted;

  assign g_masked = generator_i & CODE_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s0_valid_q <= in_valid_i;
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_act_q  <= action_i;
      s0_bad_q  <= (g_masked == '0);
      s0_r_q    <= top_bit(g_masked);
      s0_v_q    <= value_i & CODE_MASK;
      s0_g_q    <= g_masked;
      s1_item_q <= s1_item_d;
    end
  end

  always_comb begin
    shifted        = (s0_v_q << s0_r_q) & CODE_MASK;
    s1_item_d.act  = s0_act_q;
    s1_item_d.bad  = s0_bad_q;
    s1_item_d.lim  = POS_MAX - s0_r_q;
    s1_item_d.x    = (s0_act_q == ACT_CHECK) ? s0_v_q : shifted;
    s1_item_d.orig = shifted;
    s1_item_d.gn   = s0_g_q << (POS_MAX - s0_r_q);
  end

  assign valid_o = s1_valid_q;
  assign item_o  = s1_item_q;

endmodule

// ===== rtl/core/ccec_div_pipe.sv =====
// long division by the aligned generator, a fixed group of bit steps per stage
module ccec_div_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  ccec_pkg::ccec_item_t  item_i,
  output logic                  valid_o,
  output ccec_pkg::ccec_item_t  item_o
);
  import ccec_pkg::*;

  logic       valid_q [DIV_STAGES];
  ccec_item_t item_q  [DIV_STAGES];

  // clear bit (msb - k) by the generator shifted down k places
  function automatic ccec_item_t div_steps(ccec_item_t it, int unsigned base);
    ccec_item_t       res;
    logic [POS_W-1:0] k;
    res = it;
    for (int unsigned s = 0; s < STEPS_PER_STAGE; s++) begin
      k = POS_W'(base + s);
      if ((k <= res.lim) && res.x[POS_MAX - k]) begin
        res.x = res.x ^ (res.gn >> k);
      end
    end
    return res;
  endfunction

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic       stage_valid;
    ccec_item_t stage_in;

    if (j == 0) begin : g_head
      assign stage_valid = valid_i;
      assign stage_in    = item_i;
    end else begin : g_tail
      assign stage_valid = valid_q[j-1];
      assign stage_in    = item_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= stage_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[j] <= div_steps(stage_in, j * STEPS_PER_STAGE);
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign item_o  = item_q[DIV_STAGES-1];

endmodule

// ===== sim/cyclic_code_encode_and_check_tb.sv =====
// testbench for the cyclic code encoder and syndrome checker, self-checking against a predictor
module cyclic_code_encode_and_check_tb;
  import ccec_pkg::*;

  localparam int PIPE_LATENCY  = 11;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 125;

  typedef struct packed {
    logic              act;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              zero;
    logic              bad;
  } outcome_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_valid_i     = 1'b0;
  logic              cfg_ready_o;
  logic [DATA_W-1:0] cfg_generator_i = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic              action_i        = ACT_ENCODE;
  logic [DATA_W-1:0] value_i         = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [DATA_W-1:0] word_o;
  logic              syndrome_zero_o;
  logic              bad_generator_o;

  request_t          pending_requests[$];
  outcome_t          expected_results[$];
  logic [DATA_W-1:0] generator_now = GEN_RESET;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_requests = 0;
  int                holds_served  = 0;
  int                hold_left     = 0;
  int                mismatches    = 0;
  int                quiet_cycles  = 0;

  cyclic_code_encode_and_check uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_generator_i (cfg_generator_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .word_o          (word_o),
    .syndrome_zero_o (syndrome_zero_o),
    .bad_generator_o (bad_generator_o)
  );

  always #5 clk_i = ~clk_i;

  // codeword or syndrome of one request under generator gen
  function automatic outcome_t cyclic_outcome(logic act, logic [DATA_W-1:0] value,
                                              logic [DATA_W-1:0] gen);
    outcome_t          res;
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] shifted;
    logic [DATA_W-1:0] rem;
    int                deg;
    res = '0;
    g = gen & CODE_MASK;
    v = value & CODE_MASK;
    if (g == '0) begin
      res.bad = 1'b1;
      return res;
    end
    deg = 0;
    for (int i = 0; i < DATA_W; i++) begin
      if (g[i]) begin
        deg = i;
      end
    end
    shifted = (v << deg) & CODE_MASK;
    rem = (act == ACT_ENCODE) ? shifted : v;
    for (int i = DATA_W - 1; i >= deg; i--) begin
      if (rem[i]) begin
        rem = rem ^ (g << (i - deg));
      end
    end
    if (act == ACT_ENCODE) begin
      res.word = (shifted | rem) & CODE_MASK;
    end else begin
      res.word = rem & CODE_MASK;
      res.zero = (rem & CODE_MASK) == '0;
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // random generator: low degree, high degree, or a full random word
  function automatic logic [DATA_W-1:0] random_generator(int kind);
    logic [DATA_W-1:0] g;
    int                deg;
    if (kind == 2) begin
      return rand_word();
    end
    deg = (kind == 0) ? $urandom_range(16, 1) : $urandom_range(DATA_W - 1, 17);
    g = (rand_word() & ((64'd1 << deg) - 64'd1)) | (64'd1 << deg);
    if ($urandom_range(3) != 0) begin
      g[0] = 1'b1;
    end
    return g;
  endfunction

  task automatic push_request(logic act, logic [DATA_W-1:0] value);
    request_t req;
    req = '{act: act, value: value};
    pending_requests = {pending_requests, req};
  endtask

  // mostly codeword checks, some with one or two flipped bits, plus encodes and noise
  task automatic push_random(int count);
    logic [DATA_W-1:0] v;
    outcome_t          cw;
    int                pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      v = rand_word() >> $urandom_range(DATA_W - 1);
      if (pick < 30) begin
        push_request(ACT_ENCODE, ($urandom_range(3) == 0) ? rand_word() : v);
      end else if (pick < 85) begin
        cw = cyclic_outcome(ACT_ENCODE, v, generator_now);
        v = cw.word;
        if ($urandom_range(2) == 0) begin
          v[$urandom_range(DATA_W - 1)] ^= 1'b1;
          if ($urandom_range(1) == 0) begin
            v[$urandom_range(DATA_W - 1)] ^= 1'b1;
          end
        end
        push_request(ACT_CHECK, v);
      end else begin
        push_request(ACT_CHECK, ($urandom_range(1) == 0) ? rand_word() : v);
      end
    end
  endtask

  task automatic write_generator(logic [DATA_W-1:0] g);
    @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_generator_i <= g;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    generator_now = g;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  // driver: offers pending requests and predicts each accepted one
  always @(posedge clk_i) begin
    request_t req;
    outcome_t pred;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pred = cyclic_outcome(action_i, value_i, generator_now);
        expected_results = {expected_results, pred};
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          action_i   <= req.act;
          value_i    <= req.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and drives the output backpressure
  always @(posedge clk_i) begin
    outcome_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result with no request pending: word %h zero %b bad %b",
                     word_o, syndrome_zero_o, bad_generator_o);
          end
        end else begin
          want = expected_results.pop_front();
          if (word_o !== want.word || syndrome_zero_o !== want.zero ||
              bad_generator_o !== want.bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected word %h zero %b bad %b, got word %h zero %b bad %b",
                       want.word, want.zero, want.bad,
                       word_o, syndrome_zero_o, bad_generator_o);
            end
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("cyclic_code_encode_and_check_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset generator x^3 + x + 1
    push_request(ACT_ENCODE, '0);
    push_request(ACT_ENCODE, '1);
    push_request(ACT_ENCODE, 64'd1);
    push_request(ACT_CHECK, '0);
    push_request(ACT_CHECK, '1);
    push_request(ACT_CHECK, 64'hB);
    push_request(ACT_CHECK, 64'h5);
    push_request(ACT_CHECK, 64'h8000_0000_0000_0000);
    wait_drained();

    // zero generator
    write_generator('0);
    push_request(ACT_ENCODE, '1);
    push_request(ACT_CHECK, '1);
    wait_drained();

    // degree zero generator
    write_generator(64'd1);
    push_request(ACT_ENCODE, rand_word());
    push_request(ACT_CHECK, rand_word());
    push_request(ACT_CHECK, '1);
    wait_drained();

    // full degree generators
    write_generator('1);
    push_request(ACT_ENCODE, '1);
    push_request(ACT_CHECK, '1);
    push_request(ACT_CHECK, 64'h7FFF_FFFF_FFFF_FFFF);
    wait_drained();
    write_generator(64'h8000_0000_0000_0000);
    push_request(ACT_ENCODE, 64'd1);
    push_request(ACT_ENCODE, '1);
    push_request(ACT_CHECK, 64'h8000_0000_0000_0000);
    push_request(ACT_CHECK, '1);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        send_idle_pct = 6;
        recv_idle_pct = 50;
      end else if (seg < 8) begin
        send_idle_pct = 50;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_generator(random_generator(seg % 3));
      // stall the output long enough for the pipeline to back up into the request side
      if (seg == 1 || seg == 9) begin
        hold_requests++;
      end
      push_random(SEGMENT_ITEMS);
      wait_drained();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("cyclic_code_encode_and_check_tb: done, clean");
    end else begin
      $display("cyclic_code_encode_and_check_tb: done, errors");
    end
    $finish;
  end

endmodule
